// ----- sv/pndw_pkg.sv -----
package pndw_pkg;

	// Default size of the seen window, in packet numbers.
	localparam int WINDOW_BITS_DEF = 1024;

	// Field widths.
	localparam int PN_W  = 62;
	localparam int CNT_W = 32;

	// Stream data widths, filled up to whole bytes.
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 40;

	// Item kinds carried on the input tuser.
	typedef enum logic [0:0] {
		FUNC_CHECK   = 1'b0,
		FUNC_ADVANCE = 1'b1
	} func_t;

	// Control for one bitmap update.
	typedef struct packed {
		logic en;     // apply the update at this clock edge
		logic clear;  // the whole window is dropped
		logic set;    // set the flag at the given index after the shift
	} bitmap_ctrl_t;

endpackage

// ----- sv/pndw_bitmap.sv -----
module pndw_bitmap #(
	parameter int WindowBits = pndw_pkg::WINDOW_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pndw_pkg::bitmap_ctrl_t        ctrl,
	input  logic [$clog2(WindowBits)-1:0] shamt,
	input  logic [$clog2(WindowBits)-1:0] idx,
	output logic                          hit
);

	logic [WindowBits-1:0] map_q;
	logic [WindowBits-1:0] shifted;
	logic [WindowBits-1:0] set_mask;

	// Shifting toward the base drops the oldest flags; new flags come in clear.
	always_comb begin
		if (ctrl.clear) begin
			shifted = '0;
		end else begin
			shifted = map_q >> shamt;
		end
		set_mask = {{(WindowBits-1){1'b0}}, 1'b1} << idx;
		hit      = shifted[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (ctrl.en) begin
			if (ctrl.set) begin
				map_q <= shifted | set_mask;
			end else begin
				map_q <= shifted;
			end
		end
	end

endmodule

// ----- sv/packet_number_dedup_window.sv -----
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  tuser: func; tdata: pkt_num
// m_*       out        m_tvalid/m_tready  tdata: dup_flag, duplicate_total
//
// Every input transfer gives exactly one output transfer, by way of the input register and
// then the result register. A new item can be taken every cycle while the output does not
// stall, since each item sees the window base and seen bitmap as the item before left them.
// Reset clears the base, every seen flag and the duplicate count at once; no clearing pass.
// A stall on the output holds the result register and the input register, and s_tready
// falls only when both are full.
module packet_number_dedup_window #(
	parameter int WindowBits = pndw_pkg::WINDOW_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pndw_pkg::IN_TDATA_W-1:0]  s_tdata,   // [61:0] pkt_num, rest zero
	input  logic [0:0]                       s_tuser,   // [0] func
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pndw_pkg::OUT_TDATA_W-1:0] m_tdata    // [0] dup_flag,
	                                                    // [32:1] duplicate_total, rest zero
);

	localparam int IdxW = $clog2(WindowBits);
	localparam int PnW  = pndw_pkg::PN_W;
	localparam int CntW = pndw_pkg::CNT_W;

	localparam logic [PnW-1:0] WinPn     = PnW'(WindowBits);
	localparam logic [PnW-1:0] WinLastPn = PnW'(WindowBits - 1);
	localparam logic [PnW-1:0] FarPn     = PnW'(2 * WindowBits - 1);

	// Input register.
	logic                valid_s1;
	pndw_pkg::func_t     func_s1;
	logic [PnW-1:0]      pn_s1;

	// Window state and result register.
	logic [PnW-1:0]      base_q;
	logic [CntW-1:0]     cnt_q;
	logic                m_valid_q;
	logic                dup_q;

	logic                fire;
	logic [PnW:0]        off_full;
	logic                below;
	logic [PnW-1:0]      off;
	logic [PnW-1:0]      past_by;

	pndw_pkg::bitmap_ctrl_t bm_ctrl;
	logic [IdxW-1:0]     shamt;
	logic [IdxW-1:0]     idx;
	logic                hit;

	logic [PnW-1:0]      base_nxt;
	logic                dup_c;
	logic [CntW-1:0]     cnt_nxt;

	// The item in the input register is worked on when the result register can take it.
	assign fire     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= pndw_pkg::func_t'(s_tuser[0]);
			pn_s1   <= s_tdata[PnW-1:0];
		end
	end

	// Offset of the number from the window base; the top bit is the borrow.
	assign off_full = {1'b0, pn_s1} - {1'b0, base_q};
	assign below    = off_full[PnW];
	assign off      = off_full[PnW-1:0];
	// How far a checked number lies past the last slot of the window.
	assign past_by  = off - WinLastPn;

	always_comb begin
		bm_ctrl.en    = fire;
		bm_ctrl.clear = 1'b0;
		bm_ctrl.set   = 1'b0;
		shamt         = '0;
		idx           = '0;
		base_nxt      = base_q;
		dup_c         = 1'b0;
		case (func_s1)
			pndw_pkg::FUNC_CHECK: begin
				if (below) begin
					// Older than the window: always a duplicate, nothing moves.
					dup_c = 1'b1;
				end else begin
					bm_ctrl.set = 1'b1;
					if (off >= FarPn) begin
						// A full window or more ahead: start afresh at this number.
						bm_ctrl.clear = 1'b1;
						base_nxt      = pn_s1;
						idx           = '0;
					end else if (off >= WinPn) begin
						// Slide just far enough that the number takes the last slot.
						shamt    = past_by[IdxW-1:0];
						base_nxt = pn_s1 - WinLastPn;
						idx      = WinLastPn[IdxW-1:0];
					end else begin
						idx = off[IdxW-1:0];
					end
					dup_c = hit;
				end
			end
			pndw_pkg::FUNC_ADVANCE: begin
				if (!below && (off != '0)) begin
					if (off >= WinPn) begin
						bm_ctrl.clear = 1'b1;
					end else begin
						shamt = off[IdxW-1:0];
					end
					base_nxt = pn_s1;
				end
			end
			default: begin
				bm_ctrl.en = 1'b0;
			end
		endcase
	end

	// The counter sticks at its maximum.
	assign cnt_nxt = (dup_c && (cnt_q != '1)) ? cnt_q + CntW'(1) : cnt_q;

	pndw_bitmap #(
		.WindowBits(WindowBits)
	) u_bitmap (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (bm_ctrl),
		.shamt (shamt),
		.idx   (idx),
		.hit   (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				base_q    <= base_nxt;
				cnt_q     <= cnt_nxt;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dup_q <= dup_c;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(pndw_pkg::OUT_TDATA_W - CntW - 1){1'b0}}, cnt_q, dup_q};

`ifndef SYNTHESIS
	// The window only ever moves forward.
	assert property (@(posedge clk) disable iff (!arst_n) base_q >= $past(base_q))
		else $error("window base moved backwards");

	// A duplicate found adds one to the count unless it is already full.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && dup_c |=> (cnt_q == $past(cnt_q) + CntW'(1)) || ($past(cnt_q) == '1))
		else $error("duplicate not counted");

	// Without a duplicate the count stays put.
	assert property (@(posedge clk) disable iff (!arst_n) !(fire && dup_c) |=> $stable(cnt_q))
		else $error("duplicate count changed without a duplicate");

	// A waiting item is never dropped from the input register.
	assert property (@(posedge clk) disable iff (!arst_n) valid_s1 && !fire |=> valid_s1)
		else $error("pending item lost");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	localparam int WIN = pndw_pkg::WINDOW_BITS_DEF;
	localparam logic [pndw_pkg::PN_W-1:0] PN_MAX = '1;
	localparam int ITEMS_PER_PHASE = 410;
	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int MAX_PRINTED = 40;

	// One result of the filter, and one row of the directed table.
	typedef struct packed {
		logic                       dup;
		logic [pndw_pkg::CNT_W-1:0] total;
	} verdict_t;

	typedef struct packed {
		pndw_pkg::func_t           func;
		logic [pndw_pkg::PN_W-1:0] pn;
		logic                      known;  // the verdict below is typed in and used as it is
		verdict_t                  verdict;
	} probe_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [pndw_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // [61:0] pkt_num, rest zero
	logic [0:0]                       s_tuser = '0;   // [0] func
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [pndw_pkg::OUT_TDATA_W-1:0] m_tdata;        // [0] dup_flag, [32:1] duplicate_total

	// Shadow of the filter state.
	logic [pndw_pkg::PN_W-1:0]  win_base = '0;
	logic [WIN-1:0]             seen_flags = '0;
	logic [pndw_pkg::CNT_W-1:0] dup_count = '0;

	verdict_t                  pending_verdicts[$];
	logic [pndw_pkg::PN_W-1:0] recent_numbers[$];

	int  src_idle_pct = 0;
	int  sink_idle_pct = 0;
	bit  long_hold_req = 1'b0;
	int  mismatches = 0;
	int  n_checks = 0;
	int  n_advances = 0;
	int  n_dups = 0;
	int  n_results = 0;
	int  stall_cycles = 0;

	always #5 clk = ~clk;

	packet_number_dedup_window DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Applies one item to the shadow state and gives the verdict that the block owes for it.
	task automatic dedup_window_predict(input pndw_pkg::func_t func,
			input logic [pndw_pkg::PN_W-1:0] pn, output verdict_t verdict);
		logic [63:0] off;
		logic [63:0] shift;
		verdict.dup = 1'b0;
		if (func == pndw_pkg::FUNC_CHECK) begin
			if (pn < win_base) begin
				verdict.dup = 1'b1;
			end else begin
				off = 64'(pn) - 64'(win_base);
				if (off >= WIN) begin
					// The number lies past the window: slide it so the number is the newest
					// flag, or start afresh from the number if nothing would survive the slide.
					shift = off - WIN + 1;
					if (shift >= WIN) begin
						seen_flags = '0;
						win_base = pn;
					end else begin
						seen_flags = seen_flags >> shift;
						win_base = win_base + pndw_pkg::PN_W'(shift);
					end
					off = 64'(pn) - 64'(win_base);
				end
				if (seen_flags[off]) verdict.dup = 1'b1;
				else seen_flags[off] = 1'b1;
			end
			if (verdict.dup && dup_count != '1) dup_count = dup_count + 1'b1;
		end else if (pn > win_base) begin
			shift = 64'(pn) - 64'(win_base);
			if (shift >= WIN) seen_flags = '0;
			else seen_flags = seen_flags >> shift;
			win_base = pn;
		end
		verdict.total = dup_count;
	endtask

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		if (mismatches < MAX_PRINTED)
			$display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
		mismatches++;
	endtask

	// Offers one item, waits for its transfer and files the verdict that it must produce.
	task automatic offer(input pndw_pkg::func_t func, input logic [pndw_pkg::PN_W-1:0] pn,
			input logic known, input verdict_t typed);
		verdict_t verdict;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {2'b00, pn};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		dedup_window_predict(func, pn, verdict);
		pending_verdicts.push_back(known ? typed : verdict);
		if (func == pndw_pkg::FUNC_CHECK) begin
			n_checks++;
			recent_numbers.push_back(pn);
			if (recent_numbers.size() > 32) void'(recent_numbers.pop_front());
		end else begin
			n_advances++;
		end
		if (verdict.dup) n_dups++;
	endtask

	// Random item, drawn around the current window so that most items land in it, just past
	// it, or repeat a recent number; the rest are advances, jumps, stale numbers and plain noise.
	task automatic draw_item(output pndw_pkg::func_t func,
			output logic [pndw_pkg::PN_W-1:0] pn);
		int unsigned pick;
		logic [63:0] step;
		logic [63:0] noise;
		logic        relative;
		pick = $urandom_range(0, 99);
		noise = {$urandom(), $urandom()};
		func = pndw_pkg::FUNC_CHECK;
		relative = 1'b1;
		step = '0;
		pn = '0;
		if (pick < 45) begin
			step = $urandom_range(0, WIN - 1);
		end else if (pick < 60 && recent_numbers.size() != 0) begin
			pn = recent_numbers[$urandom_range(0, recent_numbers.size() - 1)];
			relative = 1'b0;
		end else if (pick < 72) begin
			step = WIN + $urandom_range(0, WIN);
		end else if (pick < 82) begin
			func = pndw_pkg::FUNC_ADVANCE;
			step = $urandom_range(0, 2 * WIN);
		end else if (pick < 88) begin
			func = pndw_pkg::func_t'($urandom_range(0, 1));
			pn = (win_base == '0) ? '0 : pndw_pkg::PN_W'(noise % 64'(win_base));
			relative = 1'b0;
		end else if (pick < 97) begin
			func = pndw_pkg::func_t'($urandom_range(0, 1));
			step = noise >> $urandom_range(20, 63);
		end else begin
			func = pndw_pkg::func_t'($urandom_range(0, 1));
			pn = pndw_pkg::PN_W'(noise);
			relative = 1'b0;
		end
		if (relative) begin
			// Near the top of the number range the window cannot slide much further.
			if (step > 64'(PN_MAX) - 64'(win_base)) pn = win_base;
			else pn = win_base + pndw_pkg::PN_W'(step);
		end
	endtask

	function automatic probe_row_t row(input pndw_pkg::func_t func,
			input logic [pndw_pkg::PN_W-1:0] pn, input logic known, input logic dup,
			input logic [pndw_pkg::CNT_W-1:0] total);
		row = '{func, pn, known, '{dup, total}};
	endfunction

	task automatic drain;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	// Stimulus.
	initial begin : stimulus
		probe_row_t opening[$];
		probe_row_t closing[$];
		pndw_pkg::func_t           func;
		logic [pndw_pkg::PN_W-1:0] pn;

		// The low end of the range, edges of the window and every kind of slide.
		opening = '{
			row(pndw_pkg::FUNC_CHECK,   62'd0,    1'b1, 1'b0, 32'd0),  // first number after reset
			row(pndw_pkg::FUNC_CHECK,   62'd0,    1'b1, 1'b1, 32'd1),  // seen again
			row(pndw_pkg::FUNC_CHECK,   62'd1023, 1'b1, 1'b0, 32'd1),  // newest flag of the window
			row(pndw_pkg::FUNC_CHECK,   62'd1023, 1'b1, 1'b1, 32'd2),
			row(pndw_pkg::FUNC_CHECK,   62'd1024, 1'b1, 1'b0, 32'd2),  // one past: slides by one
			row(pndw_pkg::FUNC_CHECK,   62'd0,    1'b1, 1'b1, 32'd3),  // fell out below the base
			row(pndw_pkg::FUNC_ADVANCE, 62'd1,    1'b1, 1'b0, 32'd3),  // acked number is the base
			row(pndw_pkg::FUNC_ADVANCE, 62'd0,    1'b1, 1'b0, 32'd3),  // acked number behind it
			row(pndw_pkg::FUNC_CHECK,   62'd1,    1'b1, 1'b0, 32'd3),
			row(pndw_pkg::FUNC_CHECK,   62'd1,    1'b1, 1'b1, 32'd4),
			row(pndw_pkg::FUNC_CHECK,   62'd1024, 1'b0, 1'b0, 32'd0),
			row(pndw_pkg::FUNC_ADVANCE, 62'd300,  1'b0, 1'b0, 32'd0),  // partial slide on advance
			row(pndw_pkg::FUNC_CHECK,   62'd1024, 1'b0, 1'b0, 32'd0),  // survived the slide
			row(pndw_pkg::FUNC_CHECK,   62'd2346, 1'b0, 1'b0, 32'd0),  // slide one short of a window
			row(pndw_pkg::FUNC_CHECK,   62'd3370, 1'b0, 1'b0, 32'd0),  // slide of a full window
			row(pndw_pkg::FUNC_CHECK,   62'd3370, 1'b0, 1'b0, 32'd0),
			row(pndw_pkg::FUNC_ADVANCE, 62'd4393, 1'b0, 1'b0, 32'd0),  // one short of a window
			row(pndw_pkg::FUNC_CHECK,   62'd4393, 1'b0, 1'b0, 32'd0),
			row(pndw_pkg::FUNC_ADVANCE, 62'd5417, 1'b0, 1'b0, 32'd0),  // advance of a full window
			row(pndw_pkg::FUNC_CHECK,   62'd5418, 1'b0, 1'b0, 32'd0)
		};
		// The base never moves back, so the top of the number range is visited last.
		closing = '{
			row(pndw_pkg::FUNC_CHECK,   PN_MAX,        1'b0, 1'b0, 32'd0),
			row(pndw_pkg::FUNC_CHECK,   PN_MAX,        1'b0, 1'b0, 32'd0),
			row(pndw_pkg::FUNC_CHECK,   PN_MAX - 1'b1, 1'b0, 1'b0, 32'd0),
			row(pndw_pkg::FUNC_ADVANCE, PN_MAX,        1'b0, 1'b0, 32'd0),
			row(pndw_pkg::FUNC_ADVANCE, 62'd0,         1'b0, 1'b0, 32'd0),
			row(pndw_pkg::FUNC_CHECK,   62'd0,         1'b0, 1'b0, 32'd0)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) offer(opening[i].func, opening[i].pn, opening[i].known,
			opening[i].verdict);

		// Three random phases: sender mostly ready, then receiver mostly ready, then neither
		// side idles. The sender waits for every verdict before it starts the next phase.
		for (int phase = 0; phase < 3; phase++) begin
			s_tvalid <= 1'b0;
			drain();
			src_idle_pct  = (phase == 0) ? 20 : (phase == 1) ? 60 : 0;
			sink_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 20 : 0;
			// With the sender offering every cycle, a long output stall fills the block.
			if (phase == 2) long_hold_req = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				draw_item(func, pn);
				offer(func, pn, 1'b0, '0);
			end
		end

		foreach (closing[i]) offer(closing[i].func, closing[i].pn, 1'b0, '0);
		s_tvalid <= 1'b0;

		drain();
		repeat (10) @(posedge clk);
		$display("Filtered %0d checks and %0d advances, %0d of them duplicates, %0d results.",
			n_checks, n_advances, n_dups, n_results);
		$display("Window slides, clears and stale numbers seen under stalls on both sides.");
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Receiver: takes results, compares them with the oldest verdict and throttles m_tready.
	initial begin : sink
		int hold_left;
		verdict_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				n_results++;
				if (pending_verdicts.size() == 0) begin
					report("result with nothing pending", '0, m_tdata);
				end else begin
					want = pending_verdicts.pop_front();
					if (m_tdata[0] !== want.dup) report("dup_flag", want.dup, m_tdata[0]);
					if (m_tdata[32:1] !== want.total)
						report("duplicate_total", want.total, m_tdata[32:1]);
				end
			end
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// Watchdog: too long without any transfer on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Timed out after %0d cycles without a transfer.", stall_cycles);
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

// ----- filelist.f -----
sv/pndw_pkg.sv
sv/pndw_bitmap.sv
sv/packet_number_dedup_window.sv
verif/tb_top.sv
